### rtl/sts_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and the reciprocal factorial table for the sine series block
package sts_pkg;

    localparam int NT_W   = 4;    // term count register width
    localparam int ANG_W  = 32;   // angle and result width
    localparam int MAG_W  = 63;   // power and coefficient magnitudes, Q1.62 / Q5.58
    localparam int ACC_W  = 64;   // series accumulator, Q7.56
    localparam int WIDE_W = 125;  // full product plus rounding constant
    localparam int RND_W  = 34;   // rounded accumulator magnitude, Q5.26 plus guard bits

    typedef struct packed {
        logic [MAG_W-1:0]        pw_mag;  // |u^k| in Q1.62
        logic                    pw_neg;  // sign of u^k
        logic [MAG_W-1:0]        u2;      // u^2 in Q1.62, never negative
        logic signed [ACC_W-1:0] acc;     // running sum
    } sts_data_t;

    // round(2^(2k+58) / k!) by restoring long division, evaluated at elaboration
    function automatic logic [MAG_W-1:0] sts_coef(input int k);
        logic [63:0]  f;
        logic [127:0] num;
        logic [64:0]  rem;
        logic [127:0] q;
        int           i;
        f   = 64'd1;
        for (i = 2; i <= k; i++) begin
            f = f * 64'(i);
        end
        num = 128'd1 << (2 * k + 58);
        rem = '0;
        q   = '0;
        for (i = 127; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            q   = q << 1;
            if (rem >= {1'b0, f}) begin
                rem  = rem - {1'b0, f};
                q[0] = 1'b1;
            end
        end
        if ({rem[63:0], 1'b0} >= {1'b0, f}) begin
            q = q + 128'd1;
        end
        return q[MAG_W-1:0];
    endfunction

endpackage

### rtl/sts_prep.sv
`timescale 1ns / 1ps
// front stage: squares the angle and forms the first power for the cell chain
module sts_prep (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        angle_rad,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sts_pkg::sts_data_t        out_data
);
    import sts_pkg::*;

    logic               vld_reg;
    logic               vld_next;
    sts_data_t          data_reg;
    logic signed [63:0] sq;
    logic [ANG_W-1:0]   mag;
    logic               take;

    assign in_ready = !vld_reg || out_ready;
    assign take     = in_valid && in_ready;

    // u = x/4 in Q0.31 is the same bit pattern, so u^2 lands in Q0.62
    assign sq  = angle_rad * angle_rad;
    assign mag = angle_rad[ANG_W-1] ? ANG_W'(-angle_rad) : ANG_W'(angle_rad);

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg.pw_mag <= {mag, 31'b0};
            data_reg.pw_neg <= angle_rad[ANG_W-1];
            data_reg.u2     <= sq[MAG_W-1:0];
            data_reg.acc    <= '0;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

### rtl/sts_cell.sv
`timescale 1ns / 1ps
// one series term: scales the incoming power by its coefficient and raises it by u^2
module sts_cell #(
    parameter int TERM = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [sts_pkg::NT_W-1:0]  n_terms,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sts_pkg::sts_data_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sts_pkg::sts_data_t        out_data
);
    import sts_pkg::*;

    localparam logic [MAG_W-1:0]  COEF     = sts_coef(2 * TERM - 1);
    localparam logic              EVEN     = (TERM % 2) == 0;
    localparam logic [NT_W-1:0]   TERM_IDX = NT_W'(TERM);
    localparam logic [WIDE_W-1:0] RND_TERM = WIDE_W'(1) << 63;
    localparam logic [WIDE_W-1:0] RND_PW   = WIDE_W'(1) << 61;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              prod_vld_reg, prod_vld_next;
    logic              phase_reg, phase_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        off_reg, off_next;
    logic [63:0]       prod_reg, prod_next;
    logic [WIDE_W-1:0] wide_reg, wide_next;
    sts_data_t         data_reg, data_next;

    logic [31:0]       a_half;
    logic [MAG_W-1:0]  b_op;
    logic [31:0]       b_half;
    logic [63:0]       prod;
    logic [WIDE_W-1:0] addend;
    logic [WIDE_W-1:0] wide_sum;
    logic [ACC_W-1:0]  term_ext;
    logic              sub;

    // partial product of the current 32-bit halves
    assign a_half = cnt_reg[1] ? {1'b0, data_reg.pw_mag[MAG_W-1:32]} : data_reg.pw_mag[31:0];
    assign b_op   = phase_reg ? data_reg.u2 : COEF;
    assign b_half = cnt_reg[0] ? {1'b0, b_op[MAG_W-1:32]} : b_op[31:0];
    assign prod   = a_half * b_half;

    always_comb begin
        case (off_reg)
            2'd0:    addend = {61'b0, prod_reg};
            2'd1:    addend = {29'b0, prod_reg, 32'b0};
            2'd2:    addend = {prod_reg[60:0], 64'b0};
            default: addend = '0;
        endcase
    end

    assign wide_sum = wide_reg + (prod_vld_reg ? addend : '0);
    assign term_ext = {3'b0, wide_reg[WIDE_W-1:64]};
    assign sub      = data_reg.pw_neg ^ EVEN;

    always_comb begin
        state_next    = state_reg;
        prod_vld_next = prod_vld_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        off_next      = off_reg;
        prod_next     = prod_reg;
        wide_next     = wide_reg;
        data_next     = data_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    data_next     = in_data;
                    wide_next     = RND_TERM;
                    phase_next    = 1'b0;
                    cnt_next      = '0;
                    prod_vld_next = 1'b0;
                    // terms past the selected count pass the data through untouched
                    state_next    = (TERM_IDX <= n_terms) ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                wide_next     = wide_sum;
                prod_next     = prod;
                off_next      = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                prod_vld_next = 1'b1;
                cnt_next      = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                wide_next     = wide_sum;
                prod_vld_next = 1'b0;
                state_next    = S_FIN;
            end
            S_FIN: begin
                if (!phase_reg) begin
                    data_next.acc = sub ? data_reg.acc - $signed(term_ext)
                                        : data_reg.acc + $signed(term_ext);
                    wide_next     = RND_PW;
                    phase_next    = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_MUL;
                end else begin
                    // u^2 is never negative, so the power keeps its sign
                    data_next.pw_mag = wide_reg[WIDE_W-1:62];
                    state_next       = S_DONE;
                end
            end
            S_DONE: begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        off_reg   <= off_next;
        prod_reg  <= prod_next;
        wide_reg  <= wide_next;
        data_reg  <= data_next;
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_DONE;
    assign out_data  = data_reg;

endmodule

### rtl/sts_tail.sv
`timescale 1ns / 1ps
// back end: rounds the Q7.56 sum to Q5.26, saturates and holds the result
module sts_tail (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sts_pkg::sts_data_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               sine_value,
    output logic                      saturated
);
    import sts_pkg::*;

    logic             a_vld_reg, a_vld_next;
    logic             m_vld_reg, m_vld_next;
    logic [RND_W-1:0] rnd_reg;
    logic             neg_reg;
    logic [31:0]      val_reg;
    logic             sat_reg;

    logic             neg;
    logic [ACC_W-1:0] rnd_sum;
    logic             b_ready;
    logic             a_take;
    logic             b_take;
    logic             sat;
    logic [31:0]      val;

    assign b_ready  = !m_vld_reg || out_ready;
    assign in_ready = !a_vld_reg || b_ready;
    assign a_take   = in_valid && in_ready;
    assign b_take   = a_vld_reg && b_ready;

    // |acc| + 2^29 in one add: for negative sums ~acc + 1 gives the magnitude
    assign neg     = in_data.acc[ACC_W-1];
    assign rnd_sum = (neg ? ~in_data.acc : in_data.acc)
                   + (neg ? ACC_W'((64'd1 << 29) + 64'd1) : ACC_W'(64'd1 << 29));

    always_comb begin
        if (neg_reg) begin
            sat = (rnd_reg[RND_W-1:32] != '0) || (rnd_reg[31] && (rnd_reg[30:0] != '0));
            val = sat ? 32'h8000_0000 : 32'(-rnd_reg[31:0]);
        end else begin
            sat = rnd_reg[RND_W-1:31] != '0;
            val = sat ? 32'h7fff_ffff : rnd_reg[31:0];
        end
    end

    always_comb begin
        a_vld_next = a_vld_reg;
        m_vld_next = m_vld_reg;
        if (a_take) begin
            a_vld_next = 1'b1;
        end else if (b_take) begin
            a_vld_next = 1'b0;
        end
        if (b_take) begin
            m_vld_next = 1'b1;
        end else if (out_ready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= a_vld_next;
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take) begin
            rnd_reg <= rnd_sum[ACC_W-1:30];
            neg_reg <= neg;
        end
        if (b_take) begin
            val_reg <= val;
            sat_reg <= sat;
        end
    end

    assign out_valid  = m_vld_reg;
    assign sine_value = val_reg;
    assign saturated  = sat_reg;

endmodule

### rtl/sine_taylor_series.sv
`timescale 1ns / 1ps
// top level of the sine Taylor series block
//
// s_tdata carries an angle in radians, signed Q2.29; m_tdata returns the
// partial sine series, signed Q5.26, with m_tuser set when the sum was clipped.
// cfg_data sets how many terms are summed (0 reads as 1, above MAX_TERMS
// reads as MAX_TERMS); write it only while no transfer is in flight.
// The angle is squared in a front stage and then walks a row of MAX_TERMS
// term cells. Each cell owns one 32x32 multiplier and forms its two 63-bit
// products (power times coefficient, power times u^2) from four partial
// products each, so an active cell is busy for its whole multiply sequence
// and a skipped cell only passes the item on; a cell takes no new item
// until it has handed on the last. The chain is pipelined: each cell can
// hold a different angle. An item passes the front stage, every cell and
// the rounding and output registers of the back end.
// A synchronous low aresetn empties every stage and sets the term count to 5.
// When m_tready is low the result holds; items already in the chain wait in
// their cells, and s_tready falls once the front stage is full.
module sine_taylor_series #(
    parameter int MAX_TERMS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] angle_rad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] sine_value
    output logic        m_tuser,     // [0] saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data     // [3:0] num_terms
);
    import sts_pkg::*;

    localparam logic [NT_W-1:0] NT_RESET = NT_W'(5);
    localparam logic [NT_W-1:0] NT_MAX   = NT_W'(MAX_TERMS);

    logic [NT_W-1:0] num_terms_reg, num_terms_next;
    logic [NT_W-1:0] n_eff;

    logic            chain_valid [MAX_TERMS+1];
    logic            chain_ready [MAX_TERMS+1];
    sts_data_t       chain_data  [MAX_TERMS+1];

    assign cfg_ready = 1'b1;

    always_comb begin
        num_terms_next = num_terms_reg;
        if (cfg_valid && cfg_ready) begin
            num_terms_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_terms_reg <= NT_RESET;
        end else begin
            num_terms_reg <= num_terms_next;
        end
    end

    always_comb begin
        if (num_terms_reg == '0) begin
            n_eff = NT_W'(1);
        end else if (num_terms_reg > NT_MAX) begin
            n_eff = NT_MAX;
        end else begin
            n_eff = num_terms_reg;
        end
    end

    sts_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .angle_rad ($signed(s_tdata)),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        sts_cell #(
            .TERM (g + 1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .n_terms   (n_eff),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    sts_tail u_tail (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[MAX_TERMS]),
        .in_ready   (chain_ready[MAX_TERMS]),
        .in_data    (chain_data[MAX_TERMS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .sine_value (m_tdata),
        .saturated  (m_tuser)
    );

    // any angle in Q2.29 keeps the series well inside the Q5.26 range
    a_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tuser)
        else $error("series sum clipped for an in-range angle");

    // an accepted angle must land in the front stage
    a_prep_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> chain_valid[0])
        else $error("input transfer lost before the cell chain");

    // backpressure on the input only comes from a full front stage
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> chain_valid[0] && !chain_ready[0])
        else $error("input stalled with the front stage free");

endmodule

### bench/tb_sine_taylor_series.sv
`timescale 1ns / 1ps
// self-checking testbench for the sine taylor series block
module tb_sine_taylor_series;

    import sts_pkg::*;

    localparam int TERM_LIMIT   = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 200;
    localparam logic [ANG_W-1:0] ANG_PI_HALF = 32'd843314857;   // pi/2 in Q2.29
    localparam logic [ANG_W-1:0] ANG_PI      = 32'd1686629713;  // pi in Q2.29
    localparam logic [ANG_W-1:0] ANG_TWO     = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_MAX     = 32'h7FFF_FFFF;
    localparam logic [ANG_W-1:0] ANG_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic [ANG_W-1:0] sine_value;
        logic             saturated;
    } sine_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [ANG_W-1:0] s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [ANG_W-1:0] m_tdata;
    logic             m_tuser;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [NT_W-1:0]  cfg_data;

    sine_result_t     pending_sines[$];
    sine_result_t     oldest;
    logic [NT_W-1:0]  term_count;
    int               mismatch_count;
    bit               tx_idle_en;
    bit               rx_idle_en;
    int               rx_hold_len;

    sine_taylor_series #(
        .MAX_TERMS(TERM_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // round(2^(2k+58) / k!), the scaled reciprocal factorial in Q5.58
    function automatic logic [62:0] recip_fact(input int k);
        logic [127:0] fact;
        logic [127:0] num;
        logic [127:0] quo;
        logic [127:0] rem;
        int           i;
        fact = 128'd1;
        for (i = 2; i <= k; i++) begin
            fact = fact * i;
        end
        num = 128'd1 << (2 * k + 58);
        quo = num / fact;
        rem = num % fact;
        if ((rem << 1) >= fact) begin
            quo = quo + 128'd1;
        end
        return quo[62:0];
    endfunction

    // |a*b| >> s rounded half away from zero, clipped to int64, sign restored
    function automatic logic signed [63:0] round_mul(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int s);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [128:0] prod;
        logic [128:0] shifted;
        logic         neg;
        neg     = a[63] ^ b[63];
        ma      = a[63] ? -a : a;
        mb      = b[63] ? -b : b;
        prod    = {65'd0, ma} * {65'd0, mb};
        prod    = prod + (129'd1 << (s - 1));
        shifted = prod >> s;
        if (|shifted[128:63]) begin
            shifted = {66'd0, 63'h7FFF_FFFF_FFFF_FFFF};
        end
        return neg ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
    endfunction

    // partial sine series of the angle, powers in Q1.62, sum in Q7.56
    function automatic sine_result_t taylor_sine(input logic [ANG_W-1:0] angle,
                                                 input logic [NT_W-1:0] terms);
        sine_result_t       res;
        logic signed [63:0] x;
        logic signed [63:0] x_sq;
        logic signed [63:0] power;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] rounded;
        logic [63:0]        mag;
        int                 n;
        int                 t;
        x     = $signed(angle);
        x_sq  = x * x;
        power = x <<< 31;
        n     = terms;
        if (n < 1) begin
            n = 1;
        end
        if (n > TERM_LIMIT) begin
            n = TERM_LIMIT;
        end
        sum = '0;
        for (t = 1; t <= n; t++) begin
            term = round_mul(power, $signed({1'b0, recip_fact(2 * t - 1)}), 64);
            if (t % 2 == 1) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            power = round_mul(power, x_sq, 62);
        end
        mag     = sum[63] ? -sum : sum;
        mag     = (mag + (64'd1 << 29)) >> 30;
        rounded = sum[63] ? -$signed(mag) : $signed(mag);
        res.saturated = 1'b0;
        if (rounded > 64'sd2147483647) begin
            rounded       = 64'sd2147483647;
            res.saturated = 1'b1;
        end else if (rounded < -64'sd2147483648) begin
            rounded       = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.sine_value = rounded[ANG_W-1:0];
        return res;
    endfunction

    function automatic logic [ANG_W-1:0] pick_angle();
        logic [ANG_W-1:0] a;
        case ($urandom_range(0, 9))
            0: a = $urandom_range(0, 32'h000F_FFFF);
            1: a = -$urandom_range(0, 32'h000F_FFFF);
            2: a = ANG_MAX - $urandom_range(0, 4095);
            3: a = ANG_MIN + $urandom_range(0, 4095);
            4: a = ANG_PI + $urandom_range(0, 65535) - 32768;
            default: a = $urandom;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [ANG_W-1:0] want,
                                   input logic [ANG_W-1:0] got);
        mismatch_count++;
        $display("mismatch: %s, expected %h, got %h, terms %0d",
                 what, want, got, term_count);
    endtask

    task automatic send_angle(input logic [ANG_W-1:0] angle);
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_sines.push_back(taylor_sine(angle, term_count));
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (pending_sines.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_terms(input logic [NT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        term_count = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset term count of five
        send_angle(32'd0);
        send_angle(32'd1);
        send_angle(32'hFFFF_FFFF);
        send_angle(ANG_MAX);
        send_angle(ANG_MIN);
        send_angle(ANG_PI_HALF);
        send_angle(-ANG_PI_HALF);
        send_angle(ANG_PI);
        send_angle(ANG_TWO);
        send_angle(-ANG_TWO);
        send_angle(32'h5555_5555);
        send_angle(32'hAAAA_AAAA);
        // zero reads as a single term
        wait_results();
        write_terms(4'd0);
        send_angle(ANG_MAX);
        send_angle(ANG_MIN);
        send_angle(ANG_PI_HALF);
        // counts above the limit clamp to the limit
        wait_results();
        write_terms(4'd15);
        send_angle(ANG_MAX);
        send_angle(ANG_MIN);
        send_angle(ANG_PI);
        wait_results();
        write_terms(4'd11);
        send_angle(ANG_MAX);
        send_angle(-ANG_PI);
        wait_results();
        write_terms(4'd10);
        send_angle(ANG_MAX);
        send_angle(ANG_MIN);
        send_angle(ANG_PI_HALF);
    endtask

    task automatic test_random_terms();
        logic [NT_W-1:0] value;
        int              phase;
        int              i;
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: value = 4'd1;
                1: value = 4'd15;
                2: value = 4'd0;
                default: value = NT_W'($urandom_range(0, 15));
            endcase
            wait_results();
            write_terms(value);
            tx_idle_en = (phase != 3) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (phase != 3) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < 60; i++) begin
                send_angle(pick_angle());
            end
        end
    endtask

    // receiver stalls long enough for the chain to fill and push back
    task automatic test_output_hold();
        int i;
        wait_results();
        write_terms(4'd10);
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (i = 0; i < 40; i++) begin
            send_angle(pick_angle());
        end
    endtask

    task automatic test_sender_pause();
        int i;
        wait_results();
        write_terms(4'd3);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (i = 0; i < 20; i++) begin
            send_angle(pick_angle());
        end
        wait_results();
        for (i = 0; i < 20; i++) begin
            send_angle(pick_angle());
        end
    endtask

    task automatic test_full_rate();
        int i;
        wait_results();
        write_terms(NT_W'($urandom_range(1, 10)));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (i = 0; i < 80; i++) begin
            send_angle(pick_angle());
        end
    endtask

    task automatic finish_run();
        wait_results();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sines.size() == 0) begin
                report_mismatch("transfer with nothing pending", '0, m_tdata);
            end else begin
                oldest = pending_sines.pop_front();
                if (m_tdata !== oldest.sine_value) begin
                    report_mismatch("sine_value", oldest.sine_value, m_tdata);
                end
                if (m_tuser !== oldest.saturated) begin
                    report_mismatch("saturated", {31'd0, oldest.saturated},
                                    {31'd0, m_tuser});
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold when asked
    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (rx_hold_len > 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        term_count     = 4'd5;
        mismatch_count = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_len    = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_terms();
        test_output_hold();
        test_sender_pause();
        test_full_rate();
        finish_run();
    end

endmodule
